[hdl/miller_rabin_prime_test_defines.svh]
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define MRPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication on clk, off during rst
`define MRPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/mrpt_pkg.sv]
package mrpt_pkg;

  localparam int WORD_BITS_DEFAULT = 64;
  localparam int BASE_COUNT = 7;

  // fixed witness set, deterministic for all 64-bit values
  localparam logic [31:0] WITNESS [BASE_COUNT] = '{
    32'd2, 32'd325, 32'd9375, 32'd28178, 32'd450775, 32'd9780504, 32'd1795265022
  };

endpackage

[hdl/mrpt_mulmod.sv]
module mrpt_mulmod #(
  parameter int W  = mrpt_pkg::WORD_BITS_DEFAULT,
  parameter int YW = mrpt_pkg::WORD_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  x,
  input  logic [YW-1:0] y,
  input  logic [W-1:0]  m,
  output logic          done,
  output logic [W-1:0]  result
);

  localparam int CW = $clog2(YW + 1);

  logic          busy;
  logic          phase;
  logic [W-1:0]  acc;
  logic [W-1:0]  xr;
  logic [YW-1:0] yr;
  logic [W-1:0]  mr;
  logic [CW-1:0] cnt;

  logic [W-1:0]  addend;
  logic [W-1:0]  room;
  logic [W-1:0]  sum;
  logic          bit_end;

  // one modular add per cycle: double, then add x when the multiplier bit is set
  always_comb begin
    addend  = phase ? xr : acc;
    room    = mr - acc;
    sum     = (addend >= room) ? (addend - room) : (acc + addend);
    bit_end = phase || !yr[YW-1];
  end

  // multiplier bits scanned from the top
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= busy && !start && bit_end && (cnt == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        acc   <= '0;
        xr    <= x;
        yr    <= y;
        mr    <= m;
        cnt   <= CW'(YW);
      end else if (busy) begin
        acc <= sum;
        if (bit_end) begin
          phase <= 1'b0;
          yr    <= yr << 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            busy <= 1'b0;
          end
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

endmodule

[hdl/miller_rabin_prime_test.sv]
// candidates below 2 or even are settled by the range and parity check alone,
// odd multiples of three by one modular product (YW = max(WORD_BITS, 32));
// otherwise up to 7 bases of at most 2*WORD_BITS modular products each, a product
// running bit by bit through the shared add-and-double unit
// one candidate at a time: in_stall stays high until the result moves to the output register
// synchronous active-high rst clears the sequencer and the output valid
module miller_rabin_prime_test #(
  parameter int WORD_BITS = mrpt_pkg::WORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_prime
);

  localparam int W  = WORD_BITS;
  localparam int YW = (W > 32) ? W : 32;
  localparam int SW = $clog2(W);
  localparam int IW = $clog2(mrpt_pkg::BASE_COUNT);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_MOD3  = 11'b00000000100,
    S_SPLIT = 11'b00000001000,
    S_AMOD  = 11'b00000010000,
    S_PTEST = 11'b00000100000,
    S_PMUL  = 11'b00001000000,
    S_PSQR  = 11'b00010000000,
    S_STEST = 11'b00100000000,
    S_SSQR  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t        state;
  logic [W-1:0]  n;
  logic [W-1:0]  d;
  logic [SW-1:0] s;
  logic [SW-1:0] k;
  logic [W-1:0]  p;
  logic [W-1:0]  b;
  logic [W-1:0]  a;
  logic [W-1:0]  ex;
  logic [IW-1:0] idx;
  logic          res;

  logic          mm_start;
  logic [W-1:0]  mm_x;
  logic [YW-1:0] mm_y;
  logic [W-1:0]  mm_m;
  logic          mm_done;
  logic [W-1:0]  mm_r;
  logic [W-1:0]  n_less1;
  logic          keep_sq;
  logic          last_base;

  assign in_stall  = (state != S_IDLE);
  assign n_less1   = n - 1'b1;
  assign keep_sq   = (p != W'(1)) && (p != n_less1) && (a != '0);
  assign last_base = (idx == IW'(mrpt_pkg::BASE_COUNT - 1));

  mrpt_mulmod #(.W(W), .YW(YW)) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (mm_m),
    .done   (mm_done),
    .result (mm_r)
  );

  // operand select for the shared unit
  always_comb begin
    mm_start = 1'b0;
    mm_x     = W'(1);
    mm_y     = YW'(b);
    mm_m     = n;
    unique case (state)
      S_CHECK: begin
        if (n >= W'(2) && n[0]) begin
          mm_start = 1'b1;
          mm_y     = YW'(n);
          mm_m     = W'(3);
        end
      end
      S_SPLIT: begin
        if (d[0]) begin
          mm_start = 1'b1;
          mm_y     = YW'(mrpt_pkg::WITNESS[0]);
        end
      end
      S_PTEST: begin
        if (ex != '0) begin
          mm_start = 1'b1;
          mm_x     = ex[0] ? p : b;
        end
      end
      S_PMUL: begin
        if (mm_done && ex != W'(1)) begin
          mm_start = 1'b1;
          mm_x     = b;
        end
      end
      S_STEST: begin
        if (keep_sq && k != '0) begin
          mm_start = 1'b1;
          mm_x     = p;
          mm_y     = YW'(p);
        end else if (!keep_sq && !(p != n_less1 && k != s) && !last_base) begin
          mm_start = 1'b1;
          mm_y     = YW'(mrpt_pkg::WITNESS[idx + 1'b1]);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= candidate[W-1:0];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n < W'(2)) begin
            res   <= 1'b0;
            state <= S_OUT;
          end else if (!n[0]) begin
            res   <= (n == W'(2));
            state <= S_OUT;
          end else begin
            state <= S_MOD3;
          end
        end
        S_MOD3: begin
          if (mm_done) begin
            if (mm_r == '0) begin
              res   <= (n == W'(3));
              state <= S_OUT;
            end else begin
              d     <= n_less1;
              s     <= '0;
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + 1'b1;
          end else begin
            idx   <= '0;
            state <= S_AMOD;
          end
        end
        S_AMOD: begin
          if (mm_done) begin
            a     <= mm_r;
            b     <= mm_r;
            p     <= W'(1);
            ex    <= d;
            state <= S_PTEST;
          end
        end
        S_PTEST: begin
          if (ex == '0) begin
            k     <= s;
            state <= S_STEST;
          end else begin
            state <= ex[0] ? S_PMUL : S_PSQR;
          end
        end
        S_PMUL: begin
          if (mm_done) begin
            p <= mm_r;
            if (ex == W'(1)) begin
              ex    <= '0;
              state <= S_PTEST;
            end else begin
              state <= S_PSQR;
            end
          end
        end
        S_PSQR: begin
          if (mm_done) begin
            b     <= mm_r;
            ex    <= ex >> 1;
            state <= S_PTEST;
          end
        end
        S_STEST: begin
          if (keep_sq) begin
            if (k == '0) begin
              res   <= 1'b0;
              state <= S_OUT;
            end else begin
              k     <= k - 1'b1;
              state <= S_SSQR;
            end
          end else if (p != n_less1 && k != s) begin
            res   <= 1'b0;
            state <= S_OUT;
          end else if (last_base) begin
            res   <= 1'b1;
            state <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_AMOD;
          end
        end
        S_SSQR: begin
          if (mm_done) begin
            p     <= mm_r;
            state <= S_STEST;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            is_prime  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "miller_rabin_prime_test_defines.svh"

  `MRPT_ASSERT_NOW(a_done_in_wait, mm_done, (state == S_MOD3 || state == S_AMOD || state == S_PMUL || state == S_PSQR || state == S_SSQR))
  `MRPT_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state == S_CHECK)
  `MRPT_ASSERT_NOW(a_prime_odd, state == S_OUT && res, n[0] || n == W'(2))

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS = 64;
  localparam int BASES = 7;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 120;
  localparam int DRAIN_CYCLES = 20;

  // idle phase codes
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

  localparam logic [63:0] WITNESS_BASES [BASES] = '{
    64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] candidate;
  logic        out_valid;
  logic        out_stall;
  logic        is_prime;

  logic        prime_q[$];
  int          mismatch_count;
  int          idle_cycles;
  idle_phase_t phase;
  bit          long_hold;
  bit          stim_done;

  miller_rabin_prime_test #(.WORD_BITS(WORD_BITS)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .out_valid(out_valid), .out_stall(out_stall),
    .is_prime(is_prime)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] word_mask();
    if (WORD_BITS >= 64) return '1;
    return (64'd1 << WORD_BITS) - 64'd1;
  endfunction

  // exact modular product via 128-bit intermediate
  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // primality prediction, deterministic witness set
  function automatic logic predict_prime(logic [63:0] raw);
    logic [63:0] n, d, s, k, a, p;
    bit ran_out;
    n = raw & word_mask();
    if (n < 2 || ((n % 6) % 4) != 1) return (n | 64'd1) == 64'd3;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < BASES; i++) begin
      a = WITNESS_BASES[i] % n;
      p = powmod(a, d, n);
      ran_out = 0;
      k = s;
      while (p != 1 && p != n - 1 && a != 0) begin
        if (k == 0) begin
          ran_out = 1;
          break;
        end
        k--;
        p = mulmod(p, p, n);
      end
      if (p != n - 1 && (ran_out || k != s)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit idle_now(bit sender);
    case (phase)
      PH_SEND: return sender ? ($urandom_range(99) < 53) : 1'b0;
      PH_RECV: return sender ? 1'b0 : ($urandom_range(99) < 53);
      PH_BOTH: return $urandom_range(99) < 10;
      default: return 1'b0;
    endcase
  endfunction

  // one transfer on the input side, expectation queued at acceptance
  task automatic send_candidate(logic [63:0] value, int expect_val);
    while (idle_now(1'b1)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    candidate <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    prime_q.insert(prime_q.size(),
                   expect_val < 0 ? predict_prime(value) : logic'(expect_val));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (prime_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] random_candidate();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 64'($urandom_range(1000));
      1: v = v | 64'd1;
      2: v = {32'd0, $urandom} | 64'd1;
      3: v = v & ~64'd1;
      default: v = v | 64'd1;
    endcase
    return v;
  endfunction

  // directed rows: -1 means use the predictor
  typedef struct {
    logic [63:0] value;
    int          expected;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{64'd0, 0}, '{64'd1, 0}, '{64'd2, 1}, '{64'd3, 1}, '{64'd4, 0},
    '{64'd5, -1}, '{64'd9, 0}, '{64'd25, -1}, '{64'd97, -1},
    '{64'd325, -1}, '{64'd163, -1}, '{64'd13, -1},
    '{64'd3215031751, -1}, '{64'd561, -1}, '{64'd4294967291, -1},
    '{64'hFFFF_FFFF_FFFF_FFC5, -1}, '{64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{64'hFFFF_FFFF_FFFF_FFFE, 0}, '{64'h8000_0000_0000_0001, -1},
    '{64'd3825123056546413051, -1}, '{64'd1795265023, -1},
    '{64'd1000000007, -1}, '{64'hAAAA_AAAA_5555_5555, -1}
  };

  // stimulus
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    candidate = '0;
    stim_done = 0;
    phase = PH_NONE;
    long_hold = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (dir_rows[i]) send_candidate(dir_rows[i].value, dir_rows[i].expected);
    // receiver holds off while sender keeps offering
    // even candidates are settled by the parity check alone, so the block fills during the hold
    long_hold = 1;
    for (int i = 0; i < 4; i++) send_candidate(random_candidate() & ~64'd1, -1);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      phase = idle_phase_t'(ph);
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_candidate(random_candidate(), -1);
      wait_drained();
    end
    stim_done = 1;
  end

  // receiver stall, with one long hold counted here
  initial begin
    out_stall = 1'b0;
    wait (long_hold);
    @(negedge clk);
    out_stall <= 1'b1;
    repeat (3000) @(negedge clk);
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= idle_now(1'b0);
    end
  end

  // result checking and watchdog
  initial begin
    logic expected_val;
    mismatch_count = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles = 0;
      else idle_cycles++;
      if (!rst && out_valid && !out_stall) begin
        if (prime_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected transfer: is_prime=%0b", is_prime);
        end else begin
          expected_val = prime_q.pop_front();
          if (is_prime !== expected_val) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("is_prime mismatch: expected %0b actual %0b", expected_val, is_prime);
          end
        end
      end
      if (stim_done && prime_q.size() == 0) begin
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mrpt_pkg.sv
hdl/mrpt_mulmod.sv
hdl/miller_rabin_prime_test.sv
tb/sv/tb_top.sv
